[design/sfe_pkg.sv]
// Shared types, constants and helpers of the starfield engine.
package sfe_pkg;

  localparam int MAX_STAR_COUNT = 256;
  localparam int STAR_AW = (MAX_STAR_COUNT > 1) ? $clog2(MAX_STAR_COUNT) : 1;
  localparam int CNT_W   = $clog2(MAX_STAR_COUNT + 1);
  localparam int CMP_W   = 12;
  localparam int TOTAL_W = 9;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  localparam logic [9:0] SIZE_MIN = 10'd8;
  localparam logic [9:0] SIZE_MAX = 10'd512;

  localparam logic [7:0] SPD_STILL     = 8'h87;
  localparam logic [7:0] SPD_X_PLUS_H  = 8'h86;
  localparam logic [7:0] SPD_X_PLUS_1  = 8'h85;
  localparam logic [7:0] SPD_X_PLUS_2  = 8'h06;
  localparam logic [7:0] SPD_X_MINUS_H = 8'h80;
  localparam logic [7:0] SPD_X_MINUS_1 = 8'h82;
  localparam logic [7:0] SPD_X_MINUS_2 = 8'h81;
  localparam logic [7:0] SPD_Y_PLUS_1  = 8'h9f;
  localparam logic [7:0] SPD_Y_PLUS_H  = 8'haf;

  localparam int         LFSR_W        = 17;
  localparam logic [7:0] LFSR_LOW_ONES = 8'hff;
  localparam logic [5:0] COLOUR_MASK   = 6'h3f;

  typedef enum logic [2:0] {
    REG_ENABLE = 3'd0,
    REG_PLANE0 = 3'd1,
    REG_PLANE1 = 3'd2,
    REG_PLANE2 = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_GEN   = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_FRAME,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [10:0] x;       // half pixels
    logic [9:0]  y;       // half pixels
    logic [5:0]  colour;
    logic [1:0]  plane;
  } star_entry_t;

  typedef struct packed {
    logic       hit;
    logic       last;
    logic [9:0] col;
    logic [8:0] row;
    logic [5:0] colour;
  } scan_out_t;

  typedef logic [2:0][7:0] code_vec_t;

  function automatic logic [9:0] clamp_size(input logic [9:0] v);
    logic [9:0] r;
    if (v < SIZE_MIN) r = SIZE_MIN;
    else if (v > SIZE_MAX) r = SIZE_MAX;
    else r = v;
    return r;
  endfunction

endpackage

[design/lfsr_starfield_engine.sv]
// Starfield engine top level: control sequencer, config registers, result register.
// Each input beat yields exactly one result beat. Generate resets the star count and
// sweeps the LFSR one column per cycle over 2*W columns by H rows, ending early once
// the table holds 256 stars. A frame beat streams every held entry through the table
// RAM, one read and one write-back per cycle; when disabled or empty it moves nothing.
// A read beat or an unused mode goes straight to the result. The result beat shows in
// the same cycle as the next beat can be taken. The table needs no clearing pass after
// reset; entries beyond the star count are never returned. A new beat is taken while
// the previous result still waits in the output register.
module lfsr_starfield_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // mode[1:0], star_index[9:2], zero [15:10]
  input  logic [sfe_pkg::IN_TDATA_W-1:0]       s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // pos_x[9:0], pos_y[18:10], star_colour[24:19], star_plane[26:25],
  // visible[27], star_total[36:28], zero [39:37]
  output logic [sfe_pkg::OUT_TDATA_W-1:0]      m_tdata,
  input  logic                                 cfg_we,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import sfe_pkg::*;

  // configuration
  logic       enable;
  code_vec_t  codes;
  logic [9:0] width_reg;
  logic [9:0] height_reg;
  logic [9:0] wc;
  logic [9:0] hc;

  // control
  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [1:0]        plane_rr;
  logic [CNT_W-1:0]  iss;
  logic              pend;
  logic [STAR_AW-1:0] paddr;
  logic              rd_hit;

  logic [1:0]  in_mode;
  logic [7:0]  in_idx;
  logic        accept;
  logic        gen_full;
  logic        issue;
  logic        out_load;
  logic        scan_start;
  logic        scan_stop;

  logic               rd_en;
  logic [STAR_AW-1:0] rd_addr;
  star_entry_t        rd_data;
  logic               wr_en;
  logic [STAR_AW-1:0] wr_addr;
  star_entry_t        wr_data;
  star_entry_t        moved;
  scan_out_t          scan;

  logic [9:0]  res_x;
  logic [8:0]  res_y;
  logic [5:0]  res_colour;
  logic [1:0]  res_plane;
  logic        res_vis;

  assign in_mode  = s_tdata[1:0];
  assign in_idx   = s_tdata[9:2];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign wc       = clamp_size(width_reg);
  assign hc       = clamp_size(height_reg);
  assign gen_full = scan.hit && ((CMP_W'(count) + CMP_W'(1)) == CMP_W'(MAX_STAR_COUNT));
  assign issue    = (iss != count);

  sfe_lfsr_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .stop   (scan_stop),
    .width  (wc),
    .height (hc),
    .scan   (scan)
  );

  sfe_star_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sfe_motion u_motion (
    .entry  (rd_data),
    .codes  (codes),
    .width  (wc),
    .height (hc),
    .moved  (moved)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_t'(in_mode))
            MODE_GEN:   state_next = ST_GEN;
            MODE_FRAME: state_next = (enable && (count != '0)) ? ST_FRAME : ST_EMIT;
            default:    state_next = ST_EMIT;
          endcase
        end
      end
      ST_GEN: begin
        if (scan.last || gen_full) state_next = ST_EMIT;
      end
      ST_FRAME: begin
        if (!issue && !pend) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = STAR_AW'(in_idx);
    wr_en      = 1'b0;
    wr_addr    = paddr;
    wr_data    = moved;
    scan_start = 1'b0;
    scan_stop  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        rd_en      = accept && (in_mode == MODE_READ);
        scan_start = accept && (in_mode == MODE_GEN);
      end
      ST_GEN: begin
        wr_en          = scan.hit;
        wr_addr        = STAR_AW'(count);
        wr_data.x      = 11'({scan.col, 1'b0});
        wr_data.y      = 10'({scan.row, 1'b0});
        wr_data.colour = scan.colour;
        wr_data.plane  = plane_rr;
        scan_stop      = gen_full;
      end
      ST_FRAME: begin
        // read entry i while entry i-1 is written back: never the same address
        rd_en   = issue;
        rd_addr = STAR_AW'(iss);
        wr_en   = pend;
      end
      ST_EMIT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_FRAME) && issue;
      if (scan_start) begin
        count <= '0;
      end else if ((state == ST_GEN) && scan.hit) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      plane_rr <= 2'd0;
    end else if ((state == ST_GEN) && scan.hit) begin
      plane_rr <= (plane_rr == 2'd2) ? 2'd0 : plane_rr + 2'd1;
    end
    if (accept) begin
      iss    <= '0;
      rd_hit <= (in_mode == MODE_READ) && (CMP_W'(in_idx) < CMP_W'(count));
    end else if ((state == ST_FRAME) && issue) begin
      iss <= iss + CNT_W'(1);
    end
    paddr <= rd_addr;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      codes      <= '0;
      width_reg  <= 10'd288;
      height_reg <= 10'd224;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE: enable     <= cfg_data[0];
        REG_PLANE0: codes[0]   <= cfg_data[7:0];
        REG_PLANE1: codes[1]   <= cfg_data[7:0];
        REG_PLANE2: codes[2]   <= cfg_data[7:0];
        REG_WIDTH:  width_reg  <= cfg_data;
        REG_HEIGHT: height_reg <= cfg_data;
        default:    ;
      endcase
    end
  end

  // result assembly; only a read of a held entry returns table data
  always_comb begin
    res_x      = 10'd0;
    res_y      = 9'd0;
    res_colour = 6'd0;
    res_plane  = 2'd0;
    res_vis    = 1'b0;
    if (rd_hit) begin
      res_x      = rd_data.x[10:1];
      res_y      = rd_data.y[9:1];
      res_colour = rd_data.colour;
      res_plane  = rd_data.plane;
      res_vis    = enable && (res_x < wc) && ({1'b0, res_y} < hc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'd0, TOTAL_W'(count), res_vis, res_plane, res_colour, res_y, res_x};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(MAX_STAR_COUNT))
    else $error("star count beyond table depth");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_GEN || state == ST_FRAME))
    else $error("table write outside generate or frame");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write-back hit the same entry");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted beat left the sequencer idle");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_EMIT))
    else $error("result raised outside emit");
`endif

endmodule

[design/sfe_star_ram.sv]
// Star table memory: one write port, one registered read port.
module sfe_star_ram (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [sfe_pkg::STAR_AW-1:0]    wr_addr,
  input  sfe_pkg::star_entry_t           wr_data,
  input  logic                           rd_en,
  input  logic [sfe_pkg::STAR_AW-1:0]    rd_addr,
  output sfe_pkg::star_entry_t           rd_data
);
  import sfe_pkg::*;

  star_entry_t mem [MAX_STAR_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/sfe_lfsr_scan.sv]
// LFSR sweep over rows and columns of the doubled field, one column per cycle.
module sfe_lfsr_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 stop,
  input  logic [9:0]           width,
  input  logic [9:0]           height,
  output sfe_pkg::scan_out_t   scan
);
  import sfe_pkg::*;

  logic              busy;
  logic [LFSR_W-1:0] lfsr;
  logic [LFSR_W-1:0] lfsr_next;
  logic [9:0]        col;
  logic [8:0]        row;
  logic [9:0]        col_start;
  logic [8:0]        row_last;
  logic [5:0]        colour;

  assign lfsr_next = {lfsr[LFSR_W-2:0], ~lfsr[LFSR_W-1] ^ lfsr[4]};
  assign colour    = ~lfsr_next[13:8] & COLOUR_MASK;
  assign col_start = 10'({width, 1'b0} - 11'd1);
  assign row_last  = 9'(height - 10'd1);

  always_comb begin
    scan.hit    = busy && !lfsr_next[LFSR_W-1] && (lfsr_next[7:0] == LFSR_LOW_ONES)
                  && (colour != 6'd0);
    scan.last   = busy && (col == 10'd0) && (row == row_last);
    scan.col    = col;
    scan.row    = row;
    scan.colour = colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (stop || scan.last)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lfsr <= '0;
      col  <= col_start;
      row  <= 9'd0;
    end else if (busy) begin
      lfsr <= lfsr_next;
      if (col == 10'd0) begin
        col <= col_start;
        row <= row + 9'd1;
      end else begin
        col <= col - 10'd1;
      end
    end
  end

endmodule

[design/sfe_motion.sv]
// Per-star move by plane speed code, with wrap on the doubled field.
module sfe_motion (
  input  sfe_pkg::star_entry_t  entry,
  input  sfe_pkg::code_vec_t    codes,
  input  logic [9:0]            width,
  input  logic [9:0]            height,
  output sfe_pkg::star_entry_t  moved
);
  import sfe_pkg::*;

  logic [7:0]         code;
  logic signed [3:0]  dx;
  logic signed [3:0]  dy;
  logic signed [12:0] xs;
  logic signed [12:0] xs_lo;
  logic signed [12:0] x_period;
  logic signed [11:0] ys;
  logic signed [11:0] ys_lo;
  logic signed [11:0] y_period;

  always_comb begin
    unique case (entry.plane)
      2'd1:    code = codes[1];
      2'd2:    code = codes[2];
      default: code = codes[0];
    endcase
  end

  always_comb begin
    dx = 4'sd0;
    dy = 4'sd0;
    unique case (code)
      SPD_STILL:     ;
      SPD_X_PLUS_H:  dx = 4'sd1;
      SPD_X_PLUS_1:  dx = 4'sd2;
      SPD_X_PLUS_2:  dx = 4'sd4;
      SPD_X_MINUS_H: dx = -4'sd1;
      SPD_X_MINUS_1: dx = -4'sd2;
      SPD_X_MINUS_2: dx = -4'sd4;
      SPD_Y_PLUS_1:  dy = 4'sd2;
      SPD_Y_PLUS_H:  dy = 4'sd1;
      default:       ;
    endcase
  end

  // one add of the period if negative, then one subtract if at or past it
  always_comb begin
    x_period = $signed({1'b0, width, 2'b00});
    y_period = $signed({1'b0, height, 1'b0});
    xs       = $signed({2'b00, entry.x}) + 13'(dx);
    ys       = $signed({2'b00, entry.y}) + 12'(dy);
    xs_lo    = (xs < 13'sd0) ? xs + x_period : xs;
    ys_lo    = (ys < 12'sd0) ? ys + y_period : ys;
    moved        = entry;
    moved.x      = (xs_lo >= x_period) ? 11'(xs_lo - x_period) : xs_lo[10:0];
    moved.y      = (ys_lo >= y_period) ? 10'(ys_lo - y_period) : ys_lo[9:0];
  end

endmodule
